// ===== hdl/msa_pkg.sv =====
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types, codes and sizes for the message slot allocator.
// ----------------------------------------------------------------------------
package msa_pkg;

    localparam int SLOTS   = 32;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int ADDR_W  = 24;
    localparam int BYTES_W = 13;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    localparam logic [BYTES_W-1:0] SLOT_BYTES_RESET = BYTES_W'(160);
    localparam logic [ADDR_W-1:0]  START_RESET      = '0;

    // Command codes; the unused code behaves as a query.
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    localparam logic [STAT_W-1:0] STAT_DONE       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_FREE    = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOT_IN_USE = 2'd2;

    // Configuration register indexes (paddr bit 2).
    localparam logic REG_START_ADDRESS = 1'b0;
    localparam logic REG_SLOT_BYTES    = 1'b1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] release_base;
    } in_item_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] slot_base;
        logic [ADDR_W-1:0] oldest_base;
        logic [ADDR_W-1:0] newest_base;
        logic              free_available;
        logic              use_nonempty;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_SEARCH,
        ST_RELINK,
        ST_BASE_SLOT,
        ST_BASE_OLD,
        ST_BASE_NEW,
        ST_PUBLISH
    } state_t;

    typedef enum logic [1:0] {
        BSEL_CUR,
        BSEL_HEAD,
        BSEL_TAIL
    } bsel_t;

    typedef struct packed {
        logic  capture;
        logic  alloc;
        logic  search_start;
        logic  search_step;
        logic  relink;
        bsel_t base_sel;
        logic  load_slot;
        logic  load_oldest;
        logic  load_newest;
        logic  publish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             hit;
        logic             search_end;
        logic             out_busy;
    } dp_status_t;

endpackage

// ===== hdl/msa_ctrl.sv =====
// ----------------------------------------------------------------------------
// msa_ctrl
// Sequencer for the slot allocator: dispatch, list search, relink, report.
// ----------------------------------------------------------------------------
module msa_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  msa_pkg::dp_status_t stat,
    output msa_pkg::ctrl_cmd_t  cmd
);

    msa_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= msa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            msa_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = msa_pkg::ST_DISPATCH;
                end
            end
            msa_pkg::ST_DISPATCH: begin
                if (stat.command == msa_pkg::CMD_RELEASE) begin
                    state_next = msa_pkg::ST_SEARCH;
                end else begin
                    state_next = msa_pkg::ST_BASE_SLOT;
                end
            end
            msa_pkg::ST_SEARCH: begin
                if (stat.search_end) begin
                    state_next = msa_pkg::ST_BASE_SLOT;
                end else if (stat.hit) begin
                    state_next = msa_pkg::ST_RELINK;
                end
            end
            msa_pkg::ST_RELINK:    state_next = msa_pkg::ST_BASE_SLOT;
            msa_pkg::ST_BASE_SLOT: state_next = msa_pkg::ST_BASE_OLD;
            msa_pkg::ST_BASE_OLD:  state_next = msa_pkg::ST_BASE_NEW;
            msa_pkg::ST_BASE_NEW:  state_next = msa_pkg::ST_PUBLISH;
            msa_pkg::ST_PUBLISH: begin
                if (!stat.out_busy) begin
                    state_next = msa_pkg::ST_IDLE;
                end
            end
            default: state_next = msa_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd          = '0;
        cmd.base_sel = msa_pkg::BSEL_CUR;
        s_ready      = 1'b0;
        unique case (state_reg)
            msa_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            msa_pkg::ST_DISPATCH: begin
                cmd.alloc        = (stat.command == msa_pkg::CMD_ALLOC);
                cmd.search_start = (stat.command == msa_pkg::CMD_RELEASE);
            end
            msa_pkg::ST_SEARCH:    cmd.search_step = 1'b1;
            msa_pkg::ST_RELINK:    cmd.relink = 1'b1;
            msa_pkg::ST_BASE_SLOT: cmd.load_slot = 1'b1;
            msa_pkg::ST_BASE_OLD: begin
                cmd.base_sel    = msa_pkg::BSEL_HEAD;
                cmd.load_oldest = 1'b1;
            end
            msa_pkg::ST_BASE_NEW: begin
                cmd.base_sel    = msa_pkg::BSEL_TAIL;
                cmd.load_newest = 1'b1;
            end
            msa_pkg::ST_PUBLISH:   cmd.publish = !stat.out_busy;
            default: cmd = '0;
        endcase
    end

endmodule

// ===== hdl/msa_dpath.sv =====
// ----------------------------------------------------------------------------
// msa_dpath
// Free FIFO, doubly linked in-use list, shared base address unit and the
// result register.
// ----------------------------------------------------------------------------
module msa_dpath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  msa_pkg::ctrl_cmd_t                 cmd,
    output msa_pkg::dp_status_t                stat,
    input  msa_pkg::in_item_t                  s_data,
    input  logic [msa_pkg::ADDR_W-1:0]         start_address,
    input  logic [msa_pkg::BYTES_W-1:0]        slot_bytes,
    output logic                               m_valid,
    input  logic                               m_ready,
    output msa_pkg::out_item_t                 m_data
);

    localparam int SW = msa_pkg::SLOT_W;
    localparam int CW = msa_pkg::CNT_W;
    localparam int AW = msa_pkg::ADDR_W;
    localparam int BW = msa_pkg::BYTES_W;

    logic [SW-1:0] free_queue_reg [msa_pkg::SLOTS];
    logic [SW-1:0] use_next_reg   [msa_pkg::SLOTS];
    logic [SW-1:0] use_prev_reg   [msa_pkg::SLOTS];
    logic [SW-1:0] free_head_reg;
    logic [CW-1:0] free_count_reg;
    logic [SW-1:0] use_head_reg;
    logic [SW-1:0] use_tail_reg;
    logic [CW-1:0] use_count_reg;

    logic [msa_pkg::CMD_W-1:0]  command_reg;
    logic [AW-1:0]              want_reg;
    logic [msa_pkg::STAT_W-1:0] status_reg;
    logic                       slot_ok_reg;
    logic [SW-1:0]              cur_reg;
    logic [CW-1:0]              n_reg;
    logic [AW-1:0]              slot_base_reg;
    logic [AW-1:0]              oldest_reg;
    logic [AW-1:0]              newest_reg;
    logic                       m_valid_reg;
    msa_pkg::out_item_t         m_data_reg;

    logic [SW-1:0]    base_idx;
    logic [SW+BW-1:0] prod;
    logic [AW-1:0]    base;
    logic [SW-1:0]    alloc_idx;
    logic [SW-1:0]    head_inc;
    logic [CW:0]      tail_sum;
    logic [SW-1:0]    free_tail;
    logic [SW-1:0]    nx;
    logic [SW-1:0]    pv;
    logic             is_head;
    logic             is_tail;
    logic             hit;
    logic             search_end;
    logic             out_busy;

    // One base unit, shared by the search compare and the three reports.
    always_comb begin
        case (cmd.base_sel)
            msa_pkg::BSEL_HEAD: base_idx = use_head_reg;
            msa_pkg::BSEL_TAIL: base_idx = use_tail_reg;
            default:            base_idx = cur_reg;
        endcase
        prod = {{BW{1'b0}}, base_idx} * {{SW{1'b0}}, slot_bytes};
        base = start_address + AW'(prod);
    end

    assign search_end = (n_reg == use_count_reg);
    assign hit        = !search_end && (base == want_reg);
    assign out_busy   = m_valid_reg && !m_ready;

    assign alloc_idx = free_queue_reg[free_head_reg];
    assign head_inc  = (free_head_reg == SW'(msa_pkg::SLOTS - 1)) ? '0 : free_head_reg + 1'b1;
    assign tail_sum  = (CW + 1)'(free_head_reg) + (CW + 1)'(free_count_reg);
    assign free_tail = (tail_sum >= (CW + 1)'(msa_pkg::SLOTS))
                     ? SW'(tail_sum - (CW + 1)'(msa_pkg::SLOTS)) : SW'(tail_sum);
    assign nx        = use_next_reg[cur_reg];
    assign pv        = use_prev_reg[cur_reg];
    assign is_head   = (cur_reg == use_head_reg);
    assign is_tail   = (cur_reg == use_tail_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < msa_pkg::SLOTS; i++) begin
                free_queue_reg[i] <= SW'(i);
            end
            free_head_reg  <= '0;
            free_count_reg <= CW'(msa_pkg::SLOTS);
            use_head_reg   <= '0;
            use_tail_reg   <= '0;
            use_count_reg  <= '0;
        end else begin
            if (cmd.alloc && (free_count_reg != '0)) begin
                free_head_reg            <= head_inc;
                free_count_reg           <= free_count_reg - 1'b1;
                use_next_reg[alloc_idx]  <= '0;
                use_prev_reg[alloc_idx]  <= use_tail_reg;
                if (use_count_reg == '0) begin
                    use_head_reg <= alloc_idx;
                end else begin
                    use_next_reg[use_tail_reg] <= alloc_idx;
                end
                use_tail_reg  <= alloc_idx;
                use_count_reg <= use_count_reg + 1'b1;
            end
            if (cmd.relink) begin
                if (is_head && is_tail) begin
                    use_head_reg <= '0;
                    use_tail_reg <= '0;
                end else if (is_head) begin
                    use_head_reg <= nx;
                end else if (is_tail) begin
                    use_tail_reg <= pv;
                end else begin
                    use_next_reg[pv] <= nx;
                    use_prev_reg[nx] <= pv;
                end
                use_count_reg             <= use_count_reg - 1'b1;
                free_queue_reg[free_tail] <= cur_reg;
                free_count_reg            <= free_count_reg + 1'b1;
            end
        end
    end

    // Per-item working registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            command_reg <= s_data.command;
            want_reg    <= s_data.release_base;
            status_reg  <= msa_pkg::STAT_DONE;
            slot_ok_reg <= 1'b0;
        end
        if (cmd.alloc) begin
            if (free_count_reg == '0) begin
                status_reg <= msa_pkg::STAT_NO_FREE;
            end else begin
                slot_ok_reg <= 1'b1;
                cur_reg     <= alloc_idx;
            end
        end
        if (cmd.search_start) begin
            cur_reg <= use_head_reg;
            n_reg   <= '0;
        end
        if (cmd.search_step) begin
            if (search_end) begin
                status_reg <= msa_pkg::STAT_NOT_IN_USE;
            end else if (hit) begin
                slot_ok_reg <= 1'b1;
            end else begin
                cur_reg <= use_next_reg[cur_reg];
                n_reg   <= n_reg + 1'b1;
            end
        end
        if (cmd.load_slot) begin
            slot_base_reg <= slot_ok_reg ? base : '0;
        end
        if (cmd.load_oldest) begin
            oldest_reg <= (use_count_reg != '0) ? base : '0;
        end
        if (cmd.load_newest) begin
            newest_reg <= (use_count_reg != '0) ? base : '0;
        end
        if (cmd.publish) begin
            m_data_reg.status         <= status_reg;
            m_data_reg.slot_base      <= slot_base_reg;
            m_data_reg.oldest_base    <= oldest_reg;
            m_data_reg.newest_base    <= newest_reg;
            m_data_reg.free_available <= (free_count_reg != '0);
            m_data_reg.use_nonempty   <= (use_count_reg != '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.command    = command_reg;
    assign stat.hit        = hit;
    assign stat.search_end = search_end;
    assign stat.out_busy   = out_busy;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

    // Every slot is on exactly one of the two lists.
    a_slot_conservation: assert property (@(posedge aclk) disable iff (!aresetn)
        ((CW + 1)'(free_count_reg) + (CW + 1)'(use_count_reg))
            == (CW + 1)'(msa_pkg::SLOTS))
    else $error("free and in-use counts do not add up to the pool size");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.publish |-> !(m_valid_reg && !m_ready))
    else $error("result overwritten before its transfer");

    a_alloc_empty_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.alloc && (free_count_reg == '0)) |=> (free_count_reg == '0))
    else $error("allocate with no free slot changed the free list");

    a_search_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.search_step |-> (n_reg <= use_count_reg))
    else $error("list search walked past the in-use count");

endmodule

// ===== hdl/message_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// message_slot_allocator
// Hands out and takes back equal message slots of an external memory pool.
//
//   Port group   Direction  Handshake          Payload
//   s_*          in         s_valid/s_ready    msa_pkg::in_item_t
//   m_*          out        m_valid/m_ready    msa_pkg::out_item_t
//   p*           in/out     APB, pready high   start_address, slot_bytes
//
// An allocate or query steps through dispatch, the three base loads and
// publish. A release also walks the in-use list from its head (position 0)
// and relinks the slot on a hit; a miss walks all slots in use. The list
// walk examines one slot per cycle through the single base address unit.
// Reset puts every slot on the free list at once; no clearing pass.
// An item is taken only when the previous one is finished; a held result
// stalls the sequencer in its last step until the result is transferred.
// ----------------------------------------------------------------------------
module message_slot_allocator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  msa_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output msa_pkg::out_item_t m_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [msa_pkg::ADDR_W-1:0]  start_address_reg;
    logic [msa_pkg::BYTES_W-1:0] slot_bytes_reg;
    msa_pkg::ctrl_cmd_t          cmd;
    msa_pkg::dp_status_t         stat;
    logic                        cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_address_reg <= msa_pkg::START_RESET;
            slot_bytes_reg    <= msa_pkg::SLOT_BYTES_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                msa_pkg::REG_START_ADDRESS: start_address_reg <= pwdata[msa_pkg::ADDR_W-1:0];
                msa_pkg::REG_SLOT_BYTES:    slot_bytes_reg    <= pwdata[msa_pkg::BYTES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            msa_pkg::REG_START_ADDRESS: prdata = 32'(start_address_reg);
            msa_pkg::REG_SLOT_BYTES:    prdata = 32'(slot_bytes_reg);
            default:                    prdata = '0;
        endcase
    end

    msa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    msa_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_data        (s_data),
        .start_address (start_address_reg),
        .slot_bytes    (slot_bytes_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data)
    );

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the message slot allocator. A queue-fed driver
// offers allocate, release and query commands while a monitor compares
// every result field against an in-bench model of the free FIFO and the
// in-use list. The slot spacing and start address are rewritten between
// phases, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import msa_pkg::*;

    // The fourth command code has no name in the package; it acts as a query.
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 140;
    localparam int HOLD_CYCLES = 400;
    localparam int QUIET_LIMIT = 3000;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // Model of the allocator: configuration, free FIFO and in-use list.
    logic [ADDR_W-1:0]  cfg_start = START_RESET;
    logic [BYTES_W-1:0] cfg_bytes = SLOT_BYTES_RESET;
    logic [SLOT_W-1:0]  free_fifo [SLOTS];
    logic [SLOT_W-1:0]  free_rd   = '0;
    logic [CNT_W-1:0]   free_cnt  = CNT_W'(SLOTS);
    logic [SLOT_W-1:0]  link_next [SLOTS];
    logic [SLOT_W-1:0]  link_prev [SLOTS];
    logic [SLOT_W-1:0]  busy_head = '0;
    logic [SLOT_W-1:0]  busy_tail = '0;
    logic [CNT_W-1:0]   busy_cnt  = '0;

    in_item_t  pending_cmds [$];
    out_item_t expected_results [$];
    int errors        = 0;
    bit idle_on       = 1'b1;
    int hold_requests = 0;
    int holds_started = 0;
    int hold_left     = 0;
    int ready_gap     = 0;
    int send_gap      = 0;
    int quiet_cycles  = 0;

    message_slot_allocator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic logic [ADDR_W-1:0] slot_addr(logic [SLOT_W-1:0] idx);
        logic [31:0] sum;
        sum = 32'(cfg_start) + 32'(idx) * 32'(cfg_bytes);
        return sum[ADDR_W-1:0];
    endfunction

    function automatic out_item_t predict_allocation(in_item_t item);
        out_item_t res;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] pv;
        logic hit;
        res = '0;
        res.status = STAT_DONE;
        hit = 1'b0;
        cur = busy_head;
        if (item.command == CMD_ALLOC) begin
            if (free_cnt == 0) begin
                res.status = STAT_NO_FREE;
            end else begin
                cur = free_fifo[free_rd];
                free_rd = SLOT_W'((int'(free_rd) + 1) % SLOTS);
                free_cnt = free_cnt - 1'b1;
                link_next[cur] = '0;
                link_prev[cur] = busy_tail;
                if (busy_cnt == 0) begin
                    busy_head = cur;
                end else begin
                    link_next[busy_tail] = cur;
                end
                busy_tail = cur;
                busy_cnt = busy_cnt + 1'b1;
                res.slot_base = slot_addr(cur);
            end
        end else if (item.command == CMD_RELEASE) begin
            // Walk from the oldest entry so duplicate bases free the oldest slot.
            for (int n = 0; n < int'(busy_cnt) && !hit; n++) begin
                if (slot_addr(cur) == item.release_base) begin
                    hit = 1'b1;
                end else begin
                    cur = link_next[cur];
                end
            end
            if (!hit) begin
                res.status = STAT_NOT_IN_USE;
            end else begin
                nx = link_next[cur];
                pv = link_prev[cur];
                if (cur == busy_head && cur == busy_tail) begin
                    busy_head = '0;
                    busy_tail = '0;
                end else if (cur == busy_head) begin
                    busy_head = nx;
                end else if (cur == busy_tail) begin
                    busy_tail = pv;
                end else begin
                    link_next[pv] = nx;
                    link_prev[nx] = pv;
                end
                busy_cnt = busy_cnt - 1'b1;
                free_fifo[(int'(free_rd) + int'(free_cnt)) % SLOTS] = cur;
                free_cnt = free_cnt + 1'b1;
                res.slot_base = slot_addr(cur);
            end
        end
        res.oldest_base    = (busy_cnt != 0) ? slot_addr(busy_head) : '0;
        res.newest_base    = (busy_cnt != 0) ? slot_addr(busy_tail) : '0;
        res.free_available = (free_cnt != 0);
        res.use_nonempty   = (busy_cnt != 0);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    // Mostly commands that hit the current pool layout, with some noise.
    function automatic in_item_t make_command(int alloc_pct);
        in_item_t item;
        int r;
        item.release_base = ADDR_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
            item.command = CMD_ALLOC;
        end else if (r < alloc_pct + 4) begin
            item.command = CMD_QUERY;
        end else if (r < alloc_pct + 6) begin
            item.command = CMD_UNUSED;
        end else begin
            item.command = CMD_RELEASE;
            if ($urandom_range(0, 4) != 0) begin
                item.release_base = slot_addr(SLOT_W'($urandom_range(0, SLOTS - 1)));
            end
        end
        return item;
    endfunction

    task automatic push_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] base);
        in_item_t item;
        item.command = cmd;
        item.release_base = base;
        pending_cmds.push_back(item);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch at %0t: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing pending, slot_base", 32'(got.slot_base), '0);
            return;
        end
        want = expected_results.pop_front();
        if (got.status != want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.slot_base != want.slot_base)
            report_mismatch("slot_base", 32'(got.slot_base), 32'(want.slot_base));
        if (got.oldest_base != want.oldest_base)
            report_mismatch("oldest_base", 32'(got.oldest_base), 32'(want.oldest_base));
        if (got.newest_base != want.newest_base)
            report_mismatch("newest_base", 32'(got.newest_base), 32'(want.newest_base));
        if (got.free_available != want.free_available)
            report_mismatch("free_available", 32'(got.free_available),
                            32'(want.free_available));
        if (got.use_nonempty != want.use_nonempty)
            report_mismatch("use_nonempty", 32'(got.use_nonempty), 32'(want.use_nonempty));
    endtask

    task automatic write_register(logic reg_sel, logic [31:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (reg_sel == REG_START_ADDRESS) begin
            cfg_start = value[ADDR_W-1:0];
        end else begin
            cfg_bytes = value[BYTES_W-1:0];
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (pending_cmds.size() != 0 || s_valid || expected_results.size() != 0)
            @(negedge aclk);
    endtask

    // Command driver: a transfer is predicted at the edge where it happens.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_valid && s_ready)
                expected_results.push_back(predict_allocation(s_data));
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    s_valid  <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (pending_cmds.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_data   <= pending_cmds.pop_front();
                    send_gap <= pick_gap();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor with random backpressure and requested long hold-offs.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready)
                check_result(m_data);
            if (holds_started < hold_requests) begin
                holds_started <= holds_started + 1;
                hold_left     <= HOLD_CYCLES;
                m_ready       <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_ready   <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap <= ready_gap - 1;
                m_ready   <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                ready_gap <= pick_gap();
                m_ready   <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        logic [ADDR_W-1:0]  start_val;
        logic [BYTES_W-1:0] bytes_val;
        int alloc_pct;
        for (int i = 0; i < SLOTS; i++) begin
            free_fifo[i] = SLOT_W'(i);
            link_next[i] = '0;
            link_prev[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: empty list, unknown command, head, middle and tail release,
        // unknown and stale bases, back to empty. Reset spacing of 160 bytes.
        push_command(CMD_QUERY,   24'h000000);
        push_command(CMD_RELEASE, 24'h000000);
        push_command(CMD_UNUSED,  24'hFFFFFF);
        repeat (5) push_command(CMD_ALLOC, 24'hFFFFFF);
        push_command(CMD_RELEASE, 24'd320);
        push_command(CMD_RELEASE, 24'd0);
        push_command(CMD_RELEASE, 24'd640);
        push_command(CMD_RELEASE, 24'hFFFFFF);
        push_command(CMD_RELEASE, 24'd320);
        push_command(CMD_ALLOC,   24'h000000);
        push_command(CMD_QUERY,   24'hFFFFFF);
        push_command(CMD_RELEASE, 24'd160);
        push_command(CMD_RELEASE, 24'd480);
        push_command(CMD_RELEASE, 24'd800);
        push_command(CMD_RELEASE, 24'd0);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    start_val = 24'hFFFF00;
                    bytes_val = 13'd160;
                    alloc_pct = 85;
                end
                1: begin
                    start_val = 24'h000000;
                    bytes_val = 13'd1;
                    alloc_pct = 30;
                end
                2: begin
                    start_val = 24'hFFFFFF;
                    bytes_val = 13'd4096;
                    alloc_pct = 60;
                end
                3: begin
                    // Zero spacing puts every slot on one base.
                    start_val = 24'h123456;
                    bytes_val = 13'd0;
                    alloc_pct = 50;
                end
                4: begin
                    start_val = ADDR_W'($urandom);
                    bytes_val = 13'h1FFF;
                    alloc_pct = 80;
                end
                default: begin
                    start_val = ADDR_W'($urandom);
                    bytes_val = BYTES_W'($urandom_range(1, 4096));
                    alloc_pct = 40;
                end
            endcase
            wait_drained();
            repeat (4) @(posedge aclk);
            write_register(REG_START_ADDRESS, 32'(start_val));
            write_register(REG_SLOT_BYTES, 32'(bytes_val));
            @(negedge aclk);
            idle_on = (p % 3 != 1);
            // The first phase starts behind a long receiver hold-off so the
            // block backs up and stalls the command channel.
            if (p == 0)
                hold_requests <= hold_requests + 1;
            for (int k = 0; k < PHASE_ITEMS; k++)
                pending_cmds.push_back(make_command(alloc_pct));
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
